// File: hdl/mlpq_pkg.sv
// Package for the multilevel priority queue.
// Holds field widths, status codes, controller states and the command/status structs.
// No dependencies.
package mlpq_pkg;

  // Fixed widths of the channel fields.
  localparam int KIND_W = 1;
  localparam int ID_W   = 16;
  localparam int PRIO_W = 4;
  localparam int STAT_W = 3;

  // Default sizing of the queue.
  localparam int LEVELS_DEF      = 8;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;

  // Operation kinds carried by an input beat.
  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_EXTRACTED = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_BADPRIO   = 3'd4
  } mlpq_status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_RESP
  } mlpq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;   // perform the operation of the accepted beat
    logic load;   // move the pending result into the output register
  } mlpq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } mlpq_sts_t;

endpackage

// File: hdl/mlpq_in_if.sv
// Input channel of the multilevel priority queue: valid/ready plus the request payload.
// Depends on mlpq_pkg for field widths.
interface mlpq_in_if;
  import mlpq_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   entry_id;
  logic [PRIO_W-1:0] priority_req;

  modport source (output valid, output kind, output entry_id, output priority_req,
                  input ready);
  modport sink   (input valid, input kind, input entry_id, input priority_req,
                  output ready);
endinterface

// File: hdl/mlpq_out_if.sv
// Result channel of the multilevel priority queue: valid/ready plus the result payload.
// Depends on mlpq_pkg for field widths.
interface mlpq_out_if;
  import mlpq_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   out_id;
  logic [PRIO_W-1:0] out_priority;

  modport source (output valid, output status, output out_id, output out_priority,
                  input ready);
  modport sink   (input valid, input status, input out_id, input out_priority,
                  output ready);
endinterface

// File: hdl/multi_level_priority_queue.sv
// Top level of the multilevel priority queue: controller plus datapath.
// Depends on mlpq_pkg, mlpq_in_if, mlpq_out_if, mlpq_ctrl and mlpq_datapath.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    kind, entry_id, priority_req
//   out_ch   out  valid/ready    status, out_id, out_priority
//
// Each beat is accepted and executed in S_IDLE (priority encode, pointer update and one
// access of the single-port entry memory); its result is loaded in S_RESP.
// The next beat is accepted while the previous result still waits in the output register.
// A stalled output holds the controller in its result state until the register frees.
// Reset clears the level pointers and counts; the entry memory is not cleared.
module multi_level_priority_queue #(
  parameter int LEVELS      = mlpq_pkg::LEVELS_DEF,
  parameter int LEVEL_DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF,
  parameter int ID_BITS     = mlpq_pkg::ID_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mlpq_in_if.sink    in_ch,
  mlpq_out_if.source out_ch
);
  import mlpq_pkg::*;

  mlpq_cmd_t cmd;
  mlpq_sts_t sts;

  // Sequencing of accept, execute and result load.
  mlpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Queue storage and result register.
  mlpq_datapath #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (in_ch.kind),
    .entry_id     (in_ch.entry_id),
    .priority_req (in_ch.priority_req),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .status       (out_ch.status),
    .out_id       (out_ch.out_id),
    .out_priority (out_ch.out_priority)
  );

endmodule

// File: hdl/mlpq_ctrl.sv
// Controller of the multilevel priority queue: accepts a beat, then hands the result out.
// Depends on mlpq_pkg for the state enum and the command/status structs.
module mlpq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mlpq_pkg::mlpq_sts_t sts,
  output mlpq_pkg::mlpq_cmd_t cmd
);
  import mlpq_pkg::*;

  mlpq_state_t state_r;
  mlpq_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/mlpq_datapath.sv
// Datapath of the multilevel priority queue: per-level ring pointers and counts,
// the shared entry memory, the level priority encoder and the output register.
// Depends on mlpq_pkg for widths, status codes and the command/status structs.
module mlpq_datapath #(
  parameter int LEVELS      = mlpq_pkg::LEVELS_DEF,
  parameter int LEVEL_DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF,
  parameter int ID_BITS     = mlpq_pkg::ID_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mlpq_pkg::mlpq_cmd_t         cmd,
  output mlpq_pkg::mlpq_sts_t         sts,
  input  logic [mlpq_pkg::KIND_W-1:0] kind,
  input  logic [mlpq_pkg::ID_W-1:0]   entry_id,
  input  logic [mlpq_pkg::PRIO_W-1:0] priority_req,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [mlpq_pkg::STAT_W-1:0] status,
  output logic [mlpq_pkg::ID_W-1:0]   out_id,
  output logic [mlpq_pkg::PRIO_W-1:0] out_priority
);
  import mlpq_pkg::*;

  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W     = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
  localparam int MEM_DEPTH = LEVELS * LEVEL_DEPTH;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Per-level ring state.
  logic [PTR_W-1:0] head_r [LEVELS];
  logic [PTR_W-1:0] tail_r [LEVELS];
  logic [CNT_W-1:0] cnt_r  [LEVELS];

  // Entry memory, one ring of LEVEL_DEPTH slots per level.
  logic [ID_BITS-1:0] mem [MEM_DEPTH];
  logic [ID_BITS-1:0] rdata_r;

  // Pending result between execution and the output register.
  mlpq_status_t      pend_status_r;
  logic [PRIO_W-1:0] pend_prio_r;

  // Output register.
  logic              out_valid_r;
  mlpq_status_t      out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic [PRIO_W-1:0] out_prio_r;

  logic              is_extract;
  logic              bad_prio;
  logic              level_full;
  logic [LVL_W-1:0]  ins_lvl;
  logic [LVL_W-1:0]  ext_lvl;
  logic              found;
  logic [LVL_W-1:0]  op_lvl;
  logic [PTR_W-1:0]  op_ptr;
  logic [PTR_W-1:0]  op_ptr_inc;
  logic [AW-1:0]     addr;
  logic              do_write;
  logic              do_read;
  mlpq_status_t      res_status;
  logic [PRIO_W-1:0] res_prio;

  // Decode the request and check the insert level.
  always_comb begin
    is_extract = (kind == KIND_EXTRACT);
    bad_prio   = (priority_req == '0) ||
                 ({1'b0, priority_req} > (PRIO_W + 1)'(LEVELS));
    ins_lvl    = LVL_W'(priority_req - PRIO_W'(1));
    level_full = (cnt_r[ins_lvl] == CNT_W'(LEVEL_DEPTH));
  end

  // Priority encoder: the highest non-empty level wins.
  always_comb begin
    found   = 1'b0;
    ext_lvl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (cnt_r[l] != '0) begin
        found   = 1'b1;
        ext_lvl = LVL_W'(l);
      end
    end
  end

  // Memory address of the slot being written or read, and the advanced pointer.
  always_comb begin
    op_lvl     = is_extract ? ext_lvl : ins_lvl;
    op_ptr     = is_extract ? head_r[op_lvl] : tail_r[op_lvl];
    op_ptr_inc = (op_ptr == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : op_ptr + PTR_W'(1);
    addr       = AW'(op_lvl) * AW'(LEVEL_DEPTH) + AW'(op_ptr);
    do_write   = cmd.exec && !is_extract && !bad_prio && !level_full;
    do_read    = cmd.exec && is_extract && found;
  end

  // Result of the operation.
  always_comb begin
    res_prio = '0;
    if (is_extract) begin
      if (found) begin
        res_status = ST_EXTRACTED;
        res_prio   = PRIO_W'(ext_lvl) + PRIO_W'(1);
      end else begin
        res_status = ST_EMPTY;
      end
    end else if (bad_prio) begin
      res_status = ST_BADPRIO;
    end else if (level_full) begin
      res_status = ST_FULL;
    end else begin
      res_status = ST_INSERTED;
    end
  end

  // Pointer and count update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else if (do_write) begin
      tail_r[op_lvl] <= op_ptr_inc;
      cnt_r[op_lvl]  <= cnt_r[op_lvl] + CNT_W'(1);
    end else if (do_read) begin
      head_r[op_lvl] <= op_ptr_inc;
      cnt_r[op_lvl]  <= cnt_r[op_lvl] - CNT_W'(1);
    end
  end

  // Entry memory with registered read.
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[addr] <= ID_BITS'(entry_id);
    end
    if (do_read) begin
      rdata_r <= mem[addr];
    end
  end

  // Pending result.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pend_status_r <= res_status;
      pend_prio_r   <= res_prio;
    end
  end

  // Output register; its valid bit is control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= pend_status_r;
      out_prio_r   <= pend_prio_r;
      out_id_r     <= (pend_status_r == ST_EXTRACTED) ? ID_W'(rdata_r) : '0;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign status       = out_status_r;
  assign out_id       = out_id_r;
  assign out_priority = out_prio_r;

`ifndef ASSERT_OFF
  // A load always leaves a result waiting in the output register.
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("output register not valid after a load");

  // An extracted entry always carries a nonzero priority.
  a_ext_prio: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && pend_status_r == ST_EXTRACTED) |-> (pend_prio_r != '0))
    else $error("extracted entry with zero priority");

  // An accepted insert grows its level by one entry.
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_write |=> (cnt_r[$past(op_lvl)] == $past(cnt_r[op_lvl]) + CNT_W'(1)))
    else $error("level count did not grow on insert");

  // An extract shrinks the level it served by one entry.
  a_ext_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_read |=> (cnt_r[$past(op_lvl)] == $past(cnt_r[op_lvl]) - CNT_W'(1)))
    else $error("level count did not shrink on extract");
`endif

endmodule
